// ----- design/tfr_pkg.sv -----
// Shared types, codes and field widths of the time-frequency reassignment block.
package tfr_pkg;

  // Field widths of the stream words and the configuration port.
  localparam int unsigned COL_W      = 6;
  localparam int unsigned ROW_W      = 8;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned FREQ_W     = 32;
  localparam int unsigned ENERGY_W   = 16;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_DATA_W-1:0] SCALE_RESET = 32'd65536;

  typedef enum logic [OP_W-1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_RDCLR = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREQ_ONLY   = 2'd0,
    REG_FREQ_MIN    = 2'd1,
    REG_FREQ_SCALE  = 2'd2,
    REG_DELAY_SCALE = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAG,
    S_MUL,
    S_SUM,
    S_CHECK,
    S_READ,
    S_UPDATE
  } state_e;

  typedef struct packed {
    logic capture;
    logic mag;
    logic mul;
    logic sum;
    logic check;
    logic read;
    logic commit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } status_t;

endpackage

// ----- design/tfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tfr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tfr_ctrl.sv -----
// Controller state machine: clearing pass, item sequencing and result hand-off.
module tfr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  tfr_pkg::status_t status_i,
  output tfr_pkg::cmd_t    cmd_o
);

  tfr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfr_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tfr_pkg::S_CLEAR: begin
        if (status_i.clear_last) state_d = tfr_pkg::S_IDLE;
      end
      tfr_pkg::S_IDLE: begin
        if (s_valid_i) state_d = tfr_pkg::S_MAG;
      end
      tfr_pkg::S_MAG:   state_d = tfr_pkg::S_MUL;
      tfr_pkg::S_MUL:   state_d = tfr_pkg::S_SUM;
      tfr_pkg::S_SUM:   state_d = tfr_pkg::S_CHECK;
      tfr_pkg::S_CHECK: state_d = tfr_pkg::S_READ;
      tfr_pkg::S_READ:  state_d = tfr_pkg::S_UPDATE;
      tfr_pkg::S_UPDATE: begin
        // The result register must be free before the bin is written back.
        if (status_i.out_free) state_d = tfr_pkg::S_IDLE;
      end
      default: state_d = tfr_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      tfr_pkg::S_CLEAR: cmd_o.clear = 1'b1;
      tfr_pkg::S_IDLE: begin
        s_ready_o     = 1'b1;
        cmd_o.capture = s_valid_i;
      end
      tfr_pkg::S_MAG:    cmd_o.mag    = 1'b1;
      tfr_pkg::S_MUL:    cmd_o.mul    = 1'b1;
      tfr_pkg::S_SUM:    cmd_o.sum    = 1'b1;
      tfr_pkg::S_CHECK:  cmd_o.check  = 1'b1;
      tfr_pkg::S_READ:   cmd_o.read   = 1'b1;
      tfr_pkg::S_UPDATE: cmd_o.commit = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- design/tfr_datapath.sv -----
// Datapath: configuration registers, bin arithmetic, energy grid and result register.
module tfr_datapath #(
  parameter int unsigned TIME_BINS = 64,
  parameter int unsigned FREQ_BINS = 256,
  parameter int unsigned ACC_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tfr_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [tfr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [tfr_pkg::IN_DATA_W-1:0]      s_tdata_i,
  input  logic [tfr_pkg::OP_W-1:0]           s_tuser_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [tfr_pkg::OUT_DATA_W-1:0]     m_tdata_o,
  output logic                               m_tuser_o,
  input  tfr_pkg::cmd_t                      cmd_i,
  output tfr_pkg::status_t                   status_o
);

  localparam int unsigned TB_W   = $clog2(TIME_BINS);
  localparam int unsigned FB_W   = $clog2(FREQ_BINS);
  localparam int unsigned GRID   = TIME_BINS * FREQ_BINS;
  localparam int unsigned ADDR_W = $clog2(GRID);
  localparam int unsigned VW     = (ACC_WIDTH > 32) ? ACC_WIDTH : 32;

  // Configuration registers.
  logic               freq_only_q;
  logic signed [31:0] freq_min_q;
  logic [31:0]        freq_scale_q;
  logic [31:0]        delay_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_only_q   <= 1'b0;
      freq_min_q    <= '0;
      freq_scale_q  <= tfr_pkg::SCALE_RESET;
      delay_scale_q <= tfr_pkg::SCALE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        tfr_pkg::REG_FREQ_ONLY:   freq_only_q   <= cfg_wdata_i[0];
        tfr_pkg::REG_FREQ_MIN:    freq_min_q    <= $signed(cfg_wdata_i);
        tfr_pkg::REG_FREQ_SCALE:  freq_scale_q  <= cfg_wdata_i;
        tfr_pkg::REG_DELAY_SCALE: delay_scale_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Captured input word.
  logic [1:0]         op_q;
  logic [5:0]         col_q;
  logic [7:0]         row_q;
  logic signed [15:0] delay_q;
  logic signed [31:0] ifreq_q;
  logic [15:0]        energy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= s_tuser_i;
      col_q    <= s_tdata_i[5:0];
      row_q    <= s_tdata_i[13:6];
      delay_q  <= $signed(s_tdata_i[29:14]);
      ifreq_q  <= $signed(s_tdata_i[61:30]);
      energy_q <= s_tdata_i[77:62];
    end
  end

  // Frequency offset and its magnitude.
  logic [32:0] diff_d;
  logic [32:0] mag_d, mag_q;
  logic        neg_q;

  assign diff_d = {ifreq_q[31], ifreq_q} - {freq_min_q[31], freq_min_q};
  assign mag_d  = diff_d[32] ? (33'd0 - diff_d) : diff_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mag) begin
      neg_q <= diff_d[32];
      mag_q <= mag_d;
    end
  end

  // The 33 by 32 bit frequency product is split into two partial products.
  logic [47:0]        p_lo_d, p_lo_q;
  logic [48:0]        p_hi_d, p_hi_q;
  logic signed [48:0] p_t_d, p_t_q;

  assign p_lo_d = 48'(mag_q[15:0]) * 48'(freq_scale_q);
  assign p_hi_d = 49'(mag_q[32:16]) * 49'(freq_scale_q);
  assign p_t_d  = 49'($signed(delay_q)) * 49'($signed({1'b0, delay_scale_q}));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p_lo_q <= p_lo_d;
      p_hi_q <= p_hi_d;
      p_t_q  <= p_t_d;
    end
  end

  // Full frequency product and rounded target time.
  logic [64:0]        prod_d, prod_q;
  logic [48:0]        t_round;
  logic signed [33:0] t_d, t_q;
  logic signed [33:0] col_s;

  assign prod_d  = {p_hi_q, 16'd0} + 65'(p_lo_q);
  assign t_round = p_t_q + 49'sd32768;
  assign col_s   = $signed({28'd0, col_q});
  assign t_d     = freq_only_q ? col_s : (col_s + $signed({t_round[48], t_round[48:16]}));

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      prod_q <= prod_d;
      t_q    <= t_d;
    end
  end

  // Range checks and the bin to use.
  logic [64:0]     f_round;
  logic [48:0]     f_full;
  logic [48:0]     f_sel;
  logic            neg_big;
  logic            t_ok;
  logic            f_ok;
  logic            ok_d, ok_q;
  logic [TB_W-1:0] tb_d, tb_q;
  logic [FB_W-1:0] fb_d, fb_q;
  logic [5:0]      otb_d, otb_q;
  logic [7:0]      ofb_d, ofb_q;
  logic [33:0]     col_ext;
  logic [48:0]     row_ext;

  assign f_round = prod_q + 65'd32768;
  assign f_full  = f_round[64:16];
  assign neg_big = prod_q > 65'd32768;
  assign f_sel   = neg_q ? 49'd0 : f_full;
  assign f_ok    = neg_q ? !neg_big : (f_full < 49'(FREQ_BINS));
  assign t_ok    = !t_q[33] && (t_q[32:0] < 33'(TIME_BINS));
  assign col_ext = 34'(col_q);
  assign row_ext = 49'(row_q);

  always_comb begin
    ok_d  = 1'b0;
    tb_d  = t_q[TB_W-1:0];
    fb_d  = f_sel[FB_W-1:0];
    otb_d = '0;
    ofb_d = '0;
    case (op_q)
      tfr_pkg::OP_ACC: begin
        ok_d = t_ok && f_ok;
        if (ok_d) begin
          otb_d = t_q[5:0];
          ofb_d = f_sel[7:0];
        end
      end
      tfr_pkg::OP_READ, tfr_pkg::OP_RDCLR: begin
        ok_d  = (32'(col_q) < 32'(TIME_BINS)) && (32'(row_q) < 32'(FREQ_BINS));
        tb_d  = col_ext[TB_W-1:0];
        fb_d  = row_ext[FB_W-1:0];
        otb_d = col_q;
        ofb_d = row_q;
      end
      default: ok_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      ok_q  <= ok_d;
      tb_q  <= tb_d;
      fb_q  <= fb_d;
      otb_q <= otb_d;
      ofb_q <= ofb_d;
    end
  end

  // Grid address, read issue and the clearing sweep counter.
  logic [ADDR_W-1:0] addr_d, addr_q;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;

  assign addr_d    = ADDR_W'(tb_q) * ADDR_W'(FREQ_BINS) + ADDR_W'(fb_q);
  assign clr_cnt_d = clr_cnt_q + ADDR_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      addr_q <= addr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Read-modify-write of the addressed bin.
  logic [ACC_WIDTH-1:0] cur;
  logic [ACC_WIDTH:0]   acc_sum;
  logic [ACC_WIDTH-1:0] acc_new;
  logic [ACC_WIDTH-1:0] value;
  logic [ACC_WIDTH-1:0] upd_wdata;
  logic                 upd_we;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ACC_WIDTH-1:0] ram_wdata;
  logic [VW-1:0]        value_ext;

  assign acc_sum = {1'b0, cur} + (ACC_WIDTH+1)'(energy_q);
  assign acc_new = acc_sum[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : acc_sum[ACC_WIDTH-1:0];

  always_comb begin
    value     = '0;
    upd_we    = 1'b0;
    upd_wdata = '0;
    case (op_q)
      tfr_pkg::OP_ACC: begin
        if (ok_q) begin
          value     = acc_new;
          upd_we    = 1'b1;
          upd_wdata = acc_new;
        end
      end
      tfr_pkg::OP_READ: begin
        if (ok_q) value = cur;
      end
      tfr_pkg::OP_RDCLR: begin
        if (ok_q) begin
          value  = cur;
          upd_we = 1'b1;
        end
      end
      default: value = '0;
    endcase
  end

  assign ram_we    = cmd_i.clear || (cmd_i.commit && upd_we);
  assign ram_waddr = cmd_i.clear ? clr_cnt_q : addr_q;
  assign ram_wdata = cmd_i.clear ? '0 : upd_wdata;

  tfr_ram #(
    .WIDTH (ACC_WIDTH),
    .DEPTH (GRID)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.read),
    .raddr_i (addr_d),
    .rdata_o (cur)
  );

  // Result register.
  logic        m_valid_q;
  logic [31:0] m_value_q;
  logic        m_placed_q;
  logic [5:0]  m_tb_q;
  logic [7:0]  m_fb_q;

  assign value_ext = VW'(value);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      m_value_q  <= value_ext[31:0];
      m_placed_q <= ok_q;
      m_tb_q     <= otb_q;
      m_fb_q     <= ofb_q;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {2'b00, m_fb_q, m_tb_q, m_value_q};
  assign m_tuser_o  = m_placed_q;

  assign status_o.out_free   = !m_valid_q || m_tready_i;
  assign status_o.clear_last = (clr_cnt_q == ADDR_W'(GRID - 1));

endmodule

// ----- design/time_frequency_reassignment.sv -----
// Top level of the time-frequency reassignment accumulator.
//
//  Port group   Dir  Payload
//  cfg_*_i      in   register index, 32-bit write data
//  s_axis_*     in   tdata: column, row, delay, inst_freq, energy; tuser: op
//  m_axis_*     out  tdata: bin_value, time_bin, freq_bin; tuser: placed
//
// An accepted word is worked through by the sequencer in order: offset, split product,
// rounding, range check and the read-modify-write of the energy grid. The next word
// is taken in the cycle after its result is registered; one word is worked at a time.
// After reset the grid is swept to zero, one bin a cycle, across all TIME_BINS * FREQ_BINS
// bins (16384 with the defaults); no word is taken meanwhile.
// A stalled result holds the sequencer before the write-back; a new word is still
// taken while an earlier result waits.
module time_frequency_reassignment #(
  parameter int unsigned TIME_BINS = 64,
  parameter int unsigned FREQ_BINS = 256,
  parameter int unsigned ACC_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tfr_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [tfr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // column[5:0], row[13:6], delay[29:14], inst_freq[61:30], energy[77:62], zeros
  input  logic [tfr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [tfr_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // bin_value[31:0], time_bin[37:32], freq_bin[45:38], zeros
  output logic [tfr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // placed
  output logic                           m_axis_tuser
);

  tfr_pkg::cmd_t    cmd;
  tfr_pkg::status_t status;

  tfr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  tfr_datapath #(
    .TIME_BINS (TIME_BINS),
    .FREQ_BINS (FREQ_BINS),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // The grid is never written while a word may be taken.
  a_no_write_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.commit || cmd.clear) |-> !s_axis_tready)
    else $error("grid written while the input side is ready");

  // A result appears only after a write-back step.
  a_result_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.commit))
    else $error("result shown without a committed word");

  // A word that did not land carries a zero bin value.
  a_unplaced_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("unplaced result with non-zero value");

  // One word at a time: no input is taken in the cycle after an acceptance.
  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word taken while one is in progress");

endmodule
